/* hdl/saq_pkg.sv */
// Shared types and codes of the sorted alarm queue.
package saq_pkg;

	// Request codes
	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_CADD = 2'd1;
	localparam logic [1:0] REQ_DEL  = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOOP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  owner_id;
		logic [31:0] delay_ticks;
		logic        is_submount;
		logic        has_mounts;
	} req_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [1:0] status;
		logic [7:0] fired_owner;
		logic [4:0] removed_count;
		logic       last;
	} rsp_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       latch;
		logic       calc;
		logic       insert;
		logic       del_shift;
		logic       tick;
		logic       pop;
		logic       emit;
		logic       emit_kind;
		logic [1:0] emit_status;
		logic       emit_last;
		logic       emit_removed;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] req_type;
		logic       queued;
		logic       delay_zero;
		logic       submount;
		logic       has_mounts;
		logic       full;
		logic       match_any;
		logic       del_nonzero;
		logic       head_fire;
		logic       next_fire;
		logic       slot_free;
	} dp_sts_t;

endpackage

/* hdl/saq_ctrl.sv */
// Controller state machine of the sorted alarm queue.
module saq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_type,
	output logic              req_stall,
	input  saq_pkg::dp_sts_t  sts,
	output saq_pkg::dp_cmd_t  cmd
);
	import saq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_ADD  = 6'b000100,
		S_DEL  = 6'b001000,
		S_TICK = 6'b010000,
		S_FIRE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	logic   refuse;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	// conditional add turned down for this owner
	assign refuse = (sts.req_type == REQ_CADD) &&
		(sts.submount || !sts.has_mounts || sts.queued);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.latch = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_ADD:  state_d = S_PREP;
						REQ_CADD: state_d = S_PREP;
						REQ_DEL:  state_d = S_DEL;
						REQ_TICK: state_d = S_TICK;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_PREP: begin
				cmd.calc = 1'b1;
				state_d  = S_ADD;
			end
			S_ADD: begin
				if (sts.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_STATUS;
					cmd.emit_last = 1'b1;
					if (refuse || sts.delay_zero) begin
						cmd.emit_status = ST_NOOP;
					end else if (sts.full) begin
						cmd.emit_status = ST_FULL;
					end else begin
						cmd.emit_status = ST_DONE;
						cmd.insert      = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_DEL: begin
				// one matching entry leaves per cycle
				if (sts.match_any) begin
					cmd.del_shift = 1'b1;
				end else if (sts.slot_free) begin
					cmd.emit         = 1'b1;
					cmd.emit_kind    = KIND_STATUS;
					cmd.emit_status  = sts.del_nonzero ? ST_DONE : ST_NOOP;
					cmd.emit_removed = 1'b1;
					cmd.emit_last    = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d  = S_FIRE;
			end
			S_FIRE: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					if (sts.head_fire) begin
						cmd.emit_kind   = KIND_FIRED;
						cmd.emit_status = ST_DONE;
						cmd.emit_last   = !sts.next_fire;
						cmd.pop         = 1'b1;
						if (!sts.next_fire) begin
							state_d = S_IDLE;
						end
					end else begin
						// nothing expired on this tick
						cmd.emit_kind   = KIND_STATUS;
						cmd.emit_status = ST_NOOP;
						cmd.emit_last   = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/saq_datapath.sv */
// Datapath of the sorted alarm queue: entry cells, time counter, result register.
module saq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int OWNER_BITS  = 8,
	parameter int TIME_BITS   = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  saq_pkg::req_item_t req,
	input  saq_pkg::dp_cmd_t   cmd,
	output saq_pkg::dp_sts_t   sts,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output saq_pkg::rsp_item_t rsp
);
	import saq_pkg::*;

	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int OWN_EXT = (OWNER_BITS > 8) ? OWNER_BITS : 8;
	localparam int CNT_EXT = (CW > 5) ? CW : 5;

	// entry cells, kept sorted by expiry
	logic [TIME_BITS-1:0]  exp_q [QUEUE_DEPTH];
	logic [OWNER_BITS-1:0] own_q [QUEUE_DEPTH];
	logic [TIME_BITS-1:0]  exp_d [QUEUE_DEPTH];
	logic [OWNER_BITS-1:0] own_d [QUEUE_DEPTH];
	logic [CW-1:0]         count_q;
	logic [TIME_BITS-1:0]  now_q;

	// latched request
	logic [1:0]            rq_type_q;
	logic [OWNER_BITS-1:0] rq_owner_q;
	logic [31:0]           rq_delay_q;
	logic                  rq_sub_q;
	logic                  rq_mnt_q;
	logic [TIME_BITS-1:0]  when_q;
	logic                  queued_q;
	logic [CW-1:0]         del_cnt_q;

	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic [OWN_EXT-1:0]    owner_in_ext;
	logic [OWN_EXT-1:0]    head_own_ext;
	logic [CNT_EXT-1:0]    del_cnt_ext;
	logic [QUEUE_DEPTH-1:0] valid;
	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] lt;
	logic [QUEUE_DEPTH-1:0] del_ge;
	logic [TIME_BITS:0]     when_sum;
	logic [TIME_BITS-1:0]   when_sat;
	logic                   slot_free;

	assign owner_in_ext = OWN_EXT'(req.owner_id);
	assign head_own_ext = OWN_EXT'(own_q[0]);
	assign del_cnt_ext  = CNT_EXT'(del_cnt_q);

	// per-cell occupancy, owner match and order compare
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid[i] = (CW'(i) < count_q);
			match[i] = valid[i] && (own_q[i] == rq_owner_q);
			lt[i]    = valid[i] && (exp_q[i] < when_q);
		end
	end

	// cells at and above the first match
	assign del_ge = match | (~match + QUEUE_DEPTH'(1));

	// saturating expiry time
	assign when_sum = {1'b0, now_q} + (TIME_BITS + 1)'(rq_delay_q);
	assign when_sat = when_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : when_sum[TIME_BITS-1:0];

	assign slot_free = !rsp_valid_q || !rsp_stall;

	// next contents of the cells: insert, remove one match, or pop the head
	always_comb begin
		int prv;
		int nxt;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			prv = (i == 0) ? 0 : i - 1;
			nxt = (i == QUEUE_DEPTH - 1) ? i : i + 1;
			exp_d[i] = exp_q[i];
			own_d[i] = own_q[i];
			if (cmd.insert) begin
				if (!lt[i]) begin
					if (i == 0 || lt[prv]) begin
						exp_d[i] = when_q;
						own_d[i] = rq_owner_q;
					end else begin
						exp_d[i] = exp_q[prv];
						own_d[i] = own_q[prv];
					end
				end
			end else if ((cmd.del_shift && del_ge[i]) || cmd.pop) begin
				exp_d[i] = exp_q[nxt];
				own_d[i] = own_q[nxt];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			exp_q[i] <= exp_d[i];
			own_q[i] <= own_d[i];
		end
	end

	// request latch and add preparation
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			rq_type_q  <= req.req_type;
			rq_owner_q <= OWNER_BITS'(owner_in_ext);
			rq_delay_q <= req.delay_ticks;
			rq_sub_q   <= req.is_submount;
			rq_mnt_q   <= req.has_mounts;
		end
		if (cmd.calc) begin
			when_q   <= when_sat;
			queued_q <= |match;
		end
	end

	// occupancy, time and delete counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			now_q     <= '0;
			del_cnt_q <= '0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del_shift || cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.tick && (now_q != {TIME_BITS{1'b1}})) begin
				now_q <= now_q + TIME_BITS'(1);
			end
			if (cmd.latch) begin
				del_cnt_q <= '0;
			end else if (cmd.del_shift) begin
				del_cnt_q <= del_cnt_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.result_kind   <= cmd.emit_kind;
			rsp_q.status        <= cmd.emit_status;
			rsp_q.fired_owner   <= (cmd.emit_kind == KIND_FIRED) ? head_own_ext[7:0] : 8'd0;
			rsp_q.removed_count <= cmd.emit_removed ? del_cnt_ext[4:0] : 5'd0;
			rsp_q.last          <= cmd.emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// status to the controller
	always_comb begin
		sts             = '0;
		sts.req_type    = rq_type_q;
		sts.queued      = queued_q;
		sts.delay_zero  = (rq_delay_q == 32'd0);
		sts.submount    = rq_sub_q;
		sts.has_mounts  = rq_mnt_q;
		sts.full        = (count_q == CW'(QUEUE_DEPTH));
		sts.match_any   = |match;
		sts.del_nonzero = (del_cnt_q != '0);
		sts.head_fire   = valid[0] && (exp_q[0] <= now_q);
		sts.next_fire   = valid[1] && (exp_q[1] <= now_q);
		sts.slot_free   = slot_free;
	end

endmodule

/* hdl/sorted_alarm_queue_unit.sv */
// Sorted alarm queue: cells ordered by expiry, tick counter, status and fired-alarm results.
// Add, conditional add: request latched, expiry computed, then the result registered.
// Delete: matches leave one per cycle through the cells, then a status with the count.
// Tick: time advances, then expired alarms drain one per cycle unless the result stalls.
// Result stalls add cycles; the next item is taken once the last result is registered.
// arst_n clears occupancy, time, delete count and result valid; cell data is not reset.
module sorted_alarm_queue_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int OWNER_BITS  = 8,
	parameter int TIME_BITS   = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  saq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output saq_pkg::rsp_item_t rsp
);
	import saq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	saq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	saq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.OWNER_BITS  (OWNER_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* hdl/saq_checker.sv */
// Port-level checks of the sorted alarm queue, bound to the top level.
module saq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input saq_pkg::req_item_t req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input saq_pkg::rsp_item_t rsp
);
	import saq_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// one item at a time: an accepted item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input open right after an accepted item");

	// while an item still has results to come, no new item enters
	a_burst_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("input open during a fired-alarm burst");

	// status results are single and carry a defined code
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.result_kind == KIND_STATUS) |->
			rsp.last && (rsp.status != 2'd3))
		else $error("bad status result");

endmodule

bind sorted_alarm_queue_unit saq_checker u_saq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
